@@ rtl/nfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Numeric field classifier package
// Character codes, character class and recogniser state types.
// ----------------------------------------------------------------------------
package nfc_pkg;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	typedef struct packed {
		logic is_dot;
		logic is_exp;
		logic is_sign;
		logic is_digit;
	} char_class_t;

	typedef struct packed {
		logic at_field_start;
		logic at_body_start;
		logic body_seen;
		logic dot_seen;
		logic exponent_seen;
		logic exponent_sign_allowed;
		logic field_failed;
	} nfc_flags_t;

	localparam nfc_flags_t FLAGS_CLEAR = '{
		at_field_start:        1'b1,
		at_body_start:         1'b1,
		body_seen:             1'b0,
		dot_seen:              1'b0,
		exponent_seen:         1'b0,
		exponent_sign_allowed: 1'b0,
		field_failed:          1'b0
	};

endpackage

@@ rtl/numeric_field_classifier.sv @@
// The transaction that carries the last character of a field passes the input
// register, then the result register, from which its result leaves on m_axis.
// Throughput: one character per cycle while the input does not stall, as the flags update for each character taken.
// The input stalls only while a result waits in the output register and the
// input register holds another field end.
// Reset (arst_n low) clears both valid flags and returns the field flags to field start.
// ----------------------------------------------------------------------------
// Numeric field classifier
// Checks a stream of field characters and reports per field whether it
// reads as a decimal number with optional sign, point and exponent.
// ----------------------------------------------------------------------------
module numeric_field_classifier (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] ch
	input  logic       s_axis_tuser,   // [0] no_char
	input  logic       s_axis_tlast,   // field end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata    // [0] is_numeric, [7:1] zero
);
	import nfc_pkg::*;

	// input register stage
	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        no_char_s1;
	logic        last_s1;

	// result register
	logic        out_valid_q;
	logic        out_numeric_q;

	char_class_t cls;
	logic        is_numeric;
	logic        out_free;
	logic        advance_s1;
	logic        load_out;

	// the output register can take a result this cycle
	assign out_free   = !out_valid_q || m_axis_tready;
	// only a field end needs room in the output register
	assign advance_s1 = valid_s1 && (!last_s1 || out_free);
	assign load_out   = advance_s1 && last_s1;

	assign s_axis_tready = !valid_s1 || advance_s1;

	// hold the transaction until the recogniser has taken it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1      <= s_axis_tdata;
			no_char_s1 <= s_axis_tuser;
			last_s1    <= s_axis_tlast;
		end
	end

	nfc_char_class u_class (
		.ch  (ch_s1),
		.cls (cls)
	);

	nfc_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance_s1),
		.cls        (cls),
		.no_char    (no_char_s1),
		.last       (last_s1),
		.is_numeric (is_numeric)
	);

	// result register: load at field end, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_numeric_q <= is_numeric;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_numeric_q};

endmodule

@@ rtl/nfc_char_class.sv @@
// ----------------------------------------------------------------------------
// Character classifier
// Decodes one character byte into the classes the recogniser cares about.
// ----------------------------------------------------------------------------
module nfc_char_class (
	input  logic [7:0]          ch,
	output nfc_pkg::char_class_t cls
);
	import nfc_pkg::*;

	always_comb begin
		cls.is_dot   = (ch == CH_DOT);
		cls.is_exp   = (ch == CH_LO_E) || (ch == CH_UP_E);
		cls.is_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
		cls.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
	end

endmodule

@@ rtl/nfc_state.sv @@
// ----------------------------------------------------------------------------
// Recogniser state
// Holds the per-field flags and updates them for one item per cycle while step is high.
// ----------------------------------------------------------------------------
module nfc_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  nfc_pkg::char_class_t cls,
	input  logic                 no_char,
	input  logic                 last,
	output logic                 is_numeric
);
	import nfc_pkg::*;

	nfc_flags_t flags_q;
	nfc_flags_t upd;
	nfc_flags_t flags_d;

	always_comb begin
		logic consumed;
		consumed = 1'b0;
		upd      = flags_q;
		if (!no_char && !flags_q.field_failed) begin
			if (upd.at_field_start) begin
				upd.at_field_start = 1'b0;
				consumed           = cls.is_sign;
			end
			if (!consumed && upd.exponent_sign_allowed) begin
				upd.exponent_sign_allowed = 1'b0;
				consumed                  = cls.is_sign;
			end
			if (!consumed) begin
				upd.at_body_start = 1'b0;
				upd.body_seen     = 1'b1;
				if (cls.is_dot) begin
					if (flags_q.dot_seen)
						upd.field_failed = 1'b1;
					upd.dot_seen = 1'b1;
				end else if (cls.is_exp) begin
					if (flags_q.exponent_seen || flags_q.at_body_start) begin
						upd.field_failed = 1'b1;
					end else begin
						upd.exponent_seen         = 1'b1;
						upd.exponent_sign_allowed = 1'b1;
					end
				end else if (!cls.is_digit) begin
					upd.field_failed = 1'b1;
				end
			end
		end
		is_numeric = !upd.field_failed && upd.body_seen;
		flags_d    = last ? FLAGS_CLEAR : upd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FLAGS_CLEAR;
		end else if (step) begin
			flags_q <= flags_d;
		end
	end

endmodule

@@ rtl/nfc_checker.sv @@
// ----------------------------------------------------------------------------
// Numeric field classifier checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module nfc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tready,
	input  logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	input  logic [7:0] m_axis_tdata
);

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// padding above the result bit stays zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
		else $error("result padding not zero");

	// input back-pressure only comes from a waiting result
	assert property (@(posedge clk)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// no result is offered while in reset
	assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind numeric_field_classifier nfc_checker u_nfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

@@ sim/numeric_field_classifier_test.sv @@
// ----------------------------------------------------------------------------
// Numeric field classifier testbench
// Streams text fields, one character per transaction, into the classifier
// and checks every per-field verdict against a local copy of the recogniser.
// ----------------------------------------------------------------------------
module numeric_field_classifier_test;

	import nfc_pkg::*;

	// Quiet cycles tolerated before the run is declared hung
	localparam int STALL_LIMIT = 1000;
	// Idle chance per cycle, in percent, on either side
	localparam int IDLE_PCT = 32;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] ch
	logic       s_axis_tuser = 1'b0;    // [0] no_char
	logic       s_axis_tlast = 1'b0;    // field end
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [0] is_numeric, [7:1] zero

	// Recogniser state mirrored from the transactions accepted so far
	nfc_flags_t field_flags = FLAGS_CLEAR;
	// Verdicts still owed by the block, oldest first
	logic       pending_verdicts[$];
	// Characters of the field about to be sent
	logic [7:0] field_chars[$];

	bit idle_enabled = 1'b1;
	int error_count = 0;
	int quiet_cycles = 0;
	int items_sent = 0;

	numeric_field_classifier dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Verdict prediction
	// ------------------------------------------------------------------

	function automatic bit is_sign_char(input logic [7:0] c);
		return c == CH_PLUS || c == CH_MINUS;
	endfunction

	// Advance the mirrored flags by one character of the field
	function automatic void advance_flags(input logic [7:0] c);
		logic first_body;
		if (field_flags.field_failed)
			return;
		// a leading sign is swallowed and leaves the body untouched
		if (field_flags.at_field_start) begin
			field_flags.at_field_start = 1'b0;
			if (is_sign_char(c))
				return;
		end
		// so is one sign straight after the exponent marker
		if (field_flags.exponent_sign_allowed) begin
			field_flags.exponent_sign_allowed = 1'b0;
			if (is_sign_char(c))
				return;
		end
		first_body = field_flags.at_body_start;
		field_flags.at_body_start = 1'b0;
		field_flags.body_seen = 1'b1;
		if (c == CH_DOT) begin
			if (field_flags.dot_seen)
				field_flags.field_failed = 1'b1;
			field_flags.dot_seen = 1'b1;
		end else if (c == CH_LO_E || c == CH_UP_E) begin
			// the marker may neither repeat nor open the body
			if (field_flags.exponent_seen || first_body) begin
				field_flags.field_failed = 1'b1;
			end else begin
				field_flags.exponent_seen = 1'b1;
				field_flags.exponent_sign_allowed = 1'b1;
			end
		end else if (c < CH_ZERO || c > CH_NINE) begin
			field_flags.field_failed = 1'b1;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus side
	// ------------------------------------------------------------------

	// Offer one transaction, hold it until accepted, then predict from it
	task automatic send_item(input logic [7:0] c, input logic no_char, input logic field_end);
		while (idle_enabled && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tuser  <= no_char;
		s_axis_tlast  <= field_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		if (!no_char)
			advance_flags(c);
		if (field_end) begin
			pending_verdicts = {pending_verdicts,
				!field_flags.field_failed && field_flags.body_seen};
			field_flags = FLAGS_CLEAR;
		end
	endtask

	function automatic void load_text(input string text);
		field_chars.delete();
		for (int i = 0; i < text.len(); i++)
			field_chars = {field_chars, 8'(text[i])};
	endfunction

	// Send the loaded field; close it on a character-less end if asked,
	// and scatter character-less filler transactions through it if asked
	task automatic send_field(input bit close_empty, input bit add_filler);
		int n;
		n = field_chars.size();
		if (n == 0) begin
			send_item(8'($urandom), 1'b1, 1'b1);
			return;
		end
		for (int i = 0; i < n; i++) begin
			if (add_filler && $urandom_range(0, 99) < 10)
				send_item(8'($urandom), 1'b1, 1'b0);
			send_item(field_chars[i], 1'b0, (i == n - 1) && !close_empty);
		end
		if (close_empty)
			send_item(8'($urandom), 1'b1, 1'b1);
	endtask

	function automatic logic [7:0] random_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Characters that sit on or next to a decision of the recogniser
	function automatic logic [7:0] random_special();
		case ($urandom_range(0, 10))
			0:       return CH_DOT;
			1:       return CH_LO_E;
			2:       return CH_UP_E;
			3:       return CH_PLUS;
			4:       return CH_MINUS;
			5:       return CH_ZERO;
			6:       return CH_NINE;
			7:       return CH_ZERO - 8'd1;
			8:       return CH_NINE + 8'd1;
			9:       return CH_LO_E + 8'd1;
			default: return CH_UP_E - 8'd1;
		endcase
	endfunction

	// Build a field: mostly a number with random parts, sometimes
	// damaged in one place, otherwise a short run of noise
	function automatic void make_random_field();
		int digits;
		field_chars.delete();
		if ($urandom_range(0, 99) < 70) begin
			if ($urandom_range(0, 1))
				field_chars = {field_chars, ($urandom_range(0, 1) ? CH_PLUS : CH_MINUS)};
			digits = $urandom_range(0, 4);
			repeat (digits)
				field_chars = {field_chars, random_digit()};
			if ($urandom_range(0, 1)) begin
				field_chars = {field_chars, CH_DOT};
				repeat ($urandom_range(0, 3))
					field_chars = {field_chars, random_digit()};
			end
			if ($urandom_range(0, 99) < 40) begin
				field_chars = {field_chars, ($urandom_range(0, 1) ? CH_LO_E : CH_UP_E)};
				if ($urandom_range(0, 1))
					field_chars = {field_chars,
						($urandom_range(0, 1) ? CH_PLUS : CH_MINUS)};
				repeat ($urandom_range(0, 3))
					field_chars = {field_chars, random_digit()};
			end
			if (field_chars.size() != 0 && $urandom_range(0, 99) < 20)
				field_chars[$urandom_range(0, field_chars.size() - 1)] =
					$urandom_range(0, 1) ? 8'($urandom) : random_special();
		end else begin
			repeat ($urandom_range(0, 6))
				field_chars = {field_chars,
					($urandom_range(0, 1) ? 8'($urandom) : random_special())};
		end
	endfunction

	// ------------------------------------------------------------------
	// Result side: random back-pressure and verdict checking
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		logic expected;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_verdicts.size() == 0) begin
				$error("is_numeric: expected none, actual %0d", m_axis_tdata[0]);
				error_count++;
			end else begin
				expected = pending_verdicts.pop_front();
				if (m_axis_tdata[0] !== expected) begin
					$error("is_numeric: expected %0d, actual %0d", expected,
						m_axis_tdata[0]);
					error_count++;
				end
				if (m_axis_tdata[7:1] !== 7'd0) begin
					$error("tdata padding: expected 0, actual %0h", m_axis_tdata[7:1]);
					error_count++;
				end
			end
		end
		m_axis_tready <= idle_enabled ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
	end

	// Abort when neither side has moved a transaction for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Forms the recogniser accepts, odd ones included
	task automatic test_accepted_forms();
		load_text("0");        send_field(1'b0, 1'b0);
		load_text("+1.5E-9");  send_field(1'b0, 1'b0);
		load_text("-7e");      send_field(1'b0, 1'b0);
		load_text("1e+");      send_field(1'b0, 1'b0);
		load_text(".");        send_field(1'b0, 1'b0);
		// a point after the exponent marker still passes
		load_text("2E3.4");    send_field(1'b0, 1'b0);
	endtask

	// Sign alone, misplaced or repeated markers, bytes outside the alphabet
	task automatic test_rejected_forms();
		load_text("+");        send_field(1'b0, 1'b0);
		load_text("-");        send_field(1'b0, 1'b0);
		load_text("e5");       send_field(1'b0, 1'b0);
		load_text("1e5E");     send_field(1'b0, 1'b0);
		load_text("..");       send_field(1'b0, 1'b0);
		load_text("1e--");     send_field(1'b0, 1'b0);
		field_chars = '{8'hFF};
		send_field(1'b0, 1'b0);
		field_chars = '{CH_NINE + 8'd1, 8'h80};
		send_field(1'b0, 1'b0);
	endtask

	// Empty fields, character-less field ends and filler within a field,
	// and characters after a failure
	task automatic test_field_ends();
		send_item(8'h00, 1'b1, 1'b1);
		load_text("12");
		send_field(1'b1, 1'b0);
		send_item(CH_NINE, 1'b0, 1'b0);
		send_item(CH_LO_E, 1'b1, 1'b0);
		send_item(CH_ZERO, 1'b0, 1'b1);
		load_text("a12");
		send_field(1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
	endtask

	task automatic test_random_fields(input int item_budget);
		int start;
		start = items_sent;
		while (items_sent - start < item_budget) begin
			make_random_field();
			send_field($urandom_range(0, 99) < 15, 1'b1);
		end
	endtask

	// Both sides at full rate, so consecutive field ends pass with no stall
	task automatic test_back_to_back();
		idle_enabled = 1'b0;
		for (int i = 0; i < 30; i++) begin
			// alternate one-character fields with random ones
			if (i % 2 == 0) begin
				field_chars = '{$urandom_range(0, 1) ? random_digit() : random_special()};
			end else begin
				make_random_field();
			end
			send_field(1'b0, 1'b0);
		end
		test_random_fields(60);
		idle_enabled = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_accepted_forms();
		test_rejected_forms();
		test_field_ends();
		test_random_fields(150);
		test_back_to_back();
		test_random_fields(60);

		// release the input and drain the remaining verdicts
		s_axis_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/nfc_pkg.sv
rtl/nfc_char_class.sv
rtl/nfc_state.sv
rtl/numeric_field_classifier.sv
rtl/nfc_checker.sv
sim/numeric_field_classifier_test.sv
